@@ rtl/bba_pkg.sv @@
// bba_pkg: shared types, constants and codes for the block bitmap allocator
// no dependencies
`default_nettype none
package bba_pkg;
    localparam int DescCountDef  = 16;
    localparam int BlockCountDef = 1024;
    localparam int WordBits      = 64;

    localparam logic [2:0] MODE_TEST       = 3'd0;
    localparam logic [2:0] MODE_FIRST_USED = 3'd1;
    localparam logic [2:0] MODE_NEXT_USED  = 3'd2;
    localparam logic [2:0] MODE_FIRST_FREE = 3'd3;
    localparam logic [2:0] MODE_SET        = 3'd4;
    localparam logic [2:0] MODE_CLEAR      = 3'd5;
    localparam logic [2:0] MODE_BIND       = 3'd6;
    localparam logic [2:0] MODE_UNBIND     = 3'd7;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_DESC = 3'd1;
    localparam logic [2:0] ST_NONE     = 3'd2;
    localparam logic [2:0] ST_SAME     = 3'd3;
    localparam logic [2:0] ST_NOCLOSE  = 3'd4;

    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] descriptor;
        logic [9:0] block_index;
        logic [3:0] header_slot;
    } t_in;

    typedef struct packed {
        logic [2:0] status;
        logic [9:0] found_block;
        logic       bit_value;
        logic       last_close;
        logic       write_back_needed;
    } t_out;
endpackage
`default_nettype wire

@@ rtl/bba_ram.sv @@
// bba_ram: generic single-port-write, single-read ram with registered read
// no dependencies
`default_nettype none
module bba_ram #(
    parameter int Width = 64,
    parameter int Depth = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/block_bitmap_allocator_top.sv @@
// block_bitmap_allocator_top: sequencer, descriptor/slot tables, bitmap memory
// depends on bba_pkg and bba_ram
`default_nettype none
// Usage: raise i_start with a word on i_in while o_busy is low; exactly one
// result word appears on o_out with o_done high for one cycle, and the
// receiver cannot stall it. Items run one at a time. After reset the block
// sweeps the bitmap memory to zero with o_busy high. Bind and unbind go
// straight to the result; test, set and clear read one 64-bit word, then
// test reads the bit and set and clear write the word back if the bit
// changes; searches read one 64-bit word per cycle, stopping early at the
// first hit.
module block_bitmap_allocator_top
    import bba_pkg::t_in, bba_pkg::t_out;
#(
    parameter int DescriptorCount = bba_pkg::DescCountDef,
    parameter int BlockCount      = bba_pkg::BlockCountDef
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_in  i_in,
    output logic      o_busy,
    output logic      o_done,
    output t_out      o_out
);
    import bba_pkg::*;

    localparam int DW  = $clog2(DescriptorCount);
    localparam int WordsPerSlot = (BlockCount + WordBits - 1) / WordBits;
    localparam int WW  = (WordsPerSlot > 1) ? $clog2(WordsPerSlot) : 1;
    localparam int Depth = DescriptorCount * WordsPerSlot;
    localparam int AW  = $clog2(Depth);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_RD, S_RMW, S_SCAN, S_DONE} t_state;

    t_state r_state;
    logic [AW:0]   r_clr;
    t_in           r_in;
    logic [DW-1:0] r_slot;
    logic [WW:0]   r_word;       // word being requested
    logic          r_want;
    logic [2:0]    r_stat;
    logic [9:0]    r_found;
    logic          r_bit, r_lc, r_wb;

    logic                   r_open  [DescriptorCount];
    logic [DW-1:0]          r_dslot [DescriptorCount];
    logic [4:0]             r_cnt   [DescriptorCount];
    logic                   r_dirty [DescriptorCount];

    // memory port
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [63:0]   mem_wdata, mem_rdata;

    bba_ram #(.Width(WordBits), .Depth(Depth)) u_bitmap (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // decode of the incoming word
    logic          in_desc_ok, in_open;
    logic [DW-1:0] in_d, in_slot, in_hs;
    logic          in_hs_ok;
    logic [16:0]   next_start;
    always_comb begin
        in_desc_ok = 32'(i_in.descriptor) < DescriptorCount;
        in_d       = i_in.descriptor[DW-1:0];
        in_open    = in_desc_ok && r_open[in_d];
        in_slot    = r_dslot[in_d];
        in_hs_ok   = 32'(i_in.header_slot) < DescriptorCount;
        in_hs      = i_in.header_slot[DW-1:0];
        next_start = 17'(i_in.block_index) + 17'd1;
    end

    // word address helper
    function automatic logic [AW-1:0] waddr(input logic [DW-1:0] s, input logic [WW:0] w);
        return AW'(32'(s) * WordsPerSlot + 32'(w));
    endfunction

    // scan of one read word: masked by start bit for first word
    logic [63:0] scan_bits;
    logic        scan_hit;
    logic [5:0]  scan_pos;
    logic [WW:0] r_rword;        // word index of data on mem_rdata
    logic [5:0]  r_first_bit;
    logic        r_first;
    always_comb begin
        scan_bits = r_want ? mem_rdata : ~mem_rdata;
        if (r_first) begin
            scan_bits = scan_bits & ~((64'd1 << r_first_bit) - 64'd1);
        end
        scan_hit = 1'b0;
        scan_pos = '0;
        for (int i = WordBits - 1; i >= 0; i--) begin
            if (scan_bits[i] && (32'(r_rword) * WordBits + i < BlockCount)) begin
                scan_hit = 1'b1;
                scan_pos = 6'(i);
            end
        end
    end

    logic [5:0]  bit_sel;
    logic        cur_bit;
    always_comb begin
        bit_sel = r_in.block_index[5:0];
        cur_bit = mem_rdata[bit_sel];
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = waddr(r_slot, r_word);
        mem_wdata = mem_rdata;
        mem_raddr = waddr(r_slot, r_word);
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr[AW-1:0];
            mem_wdata = '0;
        end else if (r_state == S_RMW && r_in.mode != MODE_TEST && cur_bit != r_want) begin
            mem_we = 1'b1;
            mem_wdata[bit_sel] = r_want;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            o_done  <= 1'b0;
            for (int i = 0; i < DescriptorCount; i++) begin
                r_open[i]  <= 1'b0;
                r_dslot[i] <= '0;
                r_cnt[i]   <= '0;
                r_dirty[i] <= 1'b0;
            end
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW+1)'(Depth - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_in    <= i_in;
                        r_slot  <= in_slot;
                        r_stat  <= ST_OK;
                        r_found <= '0;
                        r_bit   <= 1'b0;
                        r_lc    <= 1'b0;
                        r_wb    <= 1'b0;
                        r_first <= 1'b1;
                        r_want  <= (i_in.mode != MODE_FIRST_FREE) && (i_in.mode != MODE_CLEAR);
                        r_state <= S_DONE;
                        if (i_in.mode == MODE_BIND) begin
                            if (in_open || !in_desc_ok || !in_hs_ok) begin
                                r_stat <= ST_BAD_DESC;
                            end else begin
                                r_open[in_d]  <= 1'b1;
                                r_dslot[in_d] <= in_hs;
                                if (r_cnt[in_hs] < 5'd31) r_cnt[in_hs] <= r_cnt[in_hs] + 5'd1;
                            end
                        end else if (!in_open) begin
                            r_stat <= ST_BAD_DESC;
                        end else begin
                            case (i_in.mode)
                                MODE_TEST, MODE_SET, MODE_CLEAR: begin
                                    if (32'(i_in.block_index) >= BlockCount) begin
                                        r_stat <= ST_NONE;
                                    end else begin
                                        r_word  <= (WW+1)'(i_in.block_index >> 6);
                                        r_state <= S_RD;
                                    end
                                end
                                MODE_FIRST_USED, MODE_FIRST_FREE: begin
                                    r_word      <= '0;
                                    r_first_bit <= '0;
                                    r_state     <= S_RD;
                                end
                                MODE_NEXT_USED: begin
                                    if (32'(next_start) >= BlockCount) begin
                                        r_stat <= ST_NONE;
                                    end else begin
                                        r_word      <= (WW+1)'(next_start >> 6);
                                        r_first_bit <= next_start[5:0];
                                        r_state     <= S_RD;
                                    end
                                end
                                default: begin // unbind
                                    if (r_cnt[in_slot] == 5'd0) begin
                                        r_stat <= ST_NOCLOSE;
                                    end else begin
                                        if (r_cnt[in_slot] == 5'd1) begin
                                            r_lc <= 1'b1;
                                            r_wb <= r_dirty[in_slot];
                                            r_dirty[in_slot] <= 1'b0;
                                        end
                                        r_cnt[in_slot] <= r_cnt[in_slot] - 5'd1;
                                        r_open[in_d]   <= 1'b0;
                                        r_dslot[in_d]  <= '0;
                                    end
                                end
                            endcase
                        end
                    end
                end
                S_RD: begin
                    // read issued this cycle for r_word
                    r_rword <= r_word;
                    if (r_in.mode == MODE_TEST || r_in.mode == MODE_SET
                        || r_in.mode == MODE_CLEAR) begin
                        r_state <= S_RMW;
                    end else begin
                        r_word  <= r_word + 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                S_RMW: begin
                    if (r_in.mode == MODE_TEST) begin
                        r_bit <= cur_bit;
                    end else if (cur_bit == r_want) begin
                        r_stat <= ST_SAME;
                    end else begin
                        r_dirty[r_slot] <= 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_SCAN: begin
                    r_first <= 1'b0;
                    r_rword <= r_word;
                    if (scan_hit) begin
                        r_found <= 10'(32'(r_rword) * WordBits + 32'(scan_pos));
                        r_state <= S_DONE;
                    end else if (32'(r_rword) == WordsPerSlot - 1) begin
                        r_stat  <= ST_NONE;
                        r_state <= S_DONE;
                    end else begin
                        r_word <= r_word + 1'b1;
                    end
                end
                S_DONE: begin
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_busy                  = (r_state != S_IDLE);
        o_out.status            = r_stat;
        o_out.found_block       = (r_stat == ST_OK) ? r_found : 10'd0;
        o_out.bit_value         = r_bit;
        o_out.last_close        = r_lc;
        o_out.write_back_needed = r_wb;
    end
endmodule
`default_nettype wire
